### src/tapc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapc_pkg: shared types and constants of the track aperture plane cut
// Holds the fixed plane table (z position, radius limit, cut kind) and the
// status bundle that the plane unit returns to the track sequencer.
// ----------------------------------------------------------------------------
package tapc_pkg;

  // Plane table size and cut count limit
  localparam int TABLE_CUTS = 8;
  localparam int MAX_CUTS   = 8;
  localparam int CUT_IDX_W  = 3;
  localparam int CUT_CNT_W  = 4;

  // Plane z in 1/16 mm, radius limit as 5*R in 1/16 mm
  localparam int PLANE_ZW = 19;
  localparam int R5_W     = 17;

  localparam logic [CUT_CNT_W-1:0] ACTIVE_CUTS_RST = 4'd8;

  // Result of one plane check
  typedef struct packed {
    logic done;
    logic in_radius;
  } tapc_unit_stat_t;

  // Plane z position
  function automatic logic [PLANE_ZW-1:0] plane_z(input logic [CUT_IDX_W-1:0] idx);
    logic [PLANE_ZW-1:0] z;
    case (idx)
      3'd0:    z = 19'd95600;
      3'd1:    z = 19'd95600;
      3'd2:    z = 19'd451648;
      3'd3:    z = 19'd451648;
      3'd4:    z = 19'd204800;
      3'd5:    z = 19'd284976;
      3'd6:    z = 19'd312000;
      3'd7:    z = 19'd387200;
      default: z = '0;
    endcase
    return z;
  endfunction

  // Plane radius limit, scaled by five
  function automatic logic [R5_W-1:0] plane_r5(input logic [CUT_IDX_W-1:0] idx);
    logic [R5_W-1:0] r;
    case (idx)
      3'd0:    r = 17'd2824;
      3'd1:    r = 17'd7840;
      3'd2:    r = 17'd55200;
      3'd3:    r = 17'd96000;
      3'd4:    r = 17'd29984;
      3'd5:    r = 17'd51240;
      3'd6:    r = 17'd54400;
      3'd7:    r = 17'd84320;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Cut kind: 1 keeps tracks inside the radius, 0 keeps them outside
  function automatic logic plane_keep_inside(input logic [CUT_IDX_W-1:0] idx);
    logic k;
    case (idx)
      3'd0:    k = 1'b0;
      3'd2:    k = 1'b0;
      default: k = 1'b1;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### src/track_aperture_plane_cut.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// track_aperture_plane_cut: aperture cut of a track against fixed z planes
// Takes track points one beat at a time, checks each segment against the
// active planes it crosses and reports acceptance on the last point.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   in_pos_x, in_pos_y, in_pos_z,
//                                           in_last_point
//   out      source     out_valid/out_stall out_accepted
//   cfg      sink       cfg_we              cfg_wdata (active_cuts)
//
// For each point the block scans up to min(active_cuts, 8) planes and runs a
// plane check on every plane that the segment crosses; the shared multiplier
// of the plane unit sets the 16-step cost of each crossed plane. The first
// point of a track and every point of a rejected track skip the plane scan;
// a failing plane ends the scan at once. One point is in work at a time.
// Synchronous active-low reset clears the track and sets active_cuts to 8.
// A pending result in the output register does not block new points; only
// a last point that finds the register still full waits for it to drain.
// ----------------------------------------------------------------------------
module track_aperture_plane_cut
  import tapc_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CUT_CNT_W-1:0]   cfg_wdata,
  // point input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic [COORD_WIDTH-1:0] in_pos_z,
  input  wire logic                   in_last_point,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_accepted
);

  localparam int ZW = 33;   // compare width for z positions

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CUT_CNT_W-1:0]   active_cuts_r;
  logic [COORD_WIDTH-1:0] px_r, py_r, pz_r;
  logic [COORD_WIDTH-1:0] cx_r, cy_r, cz_r;
  logic                   last_r;
  logic                   have_prev_r;
  logic                   rejected_r;
  logic [CUT_CNT_W-1:0]   cut_r;
  logic [COORD_WIDTH-1:0] wa_r, wb_r, dz_r;
  logic [R5_W-1:0]        r5_r;
  logic                   start_r;
  logic                   out_valid_r;
  logic                   accepted_r;

  logic                   in_acc;
  logic [CUT_CNT_W-1:0]   n_cuts;
  logic [CUT_IDX_W-1:0]   cut_idx;
  logic [ZW-1:0]          zc;
  logic                   in_range;
  logic                   scan_end;
  logic                   emit_ok;
  logic                   fail;
  tapc_unit_stat_t        stat;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Saturate the cut count to the table
  assign n_cuts  = (active_cuts_r > CUT_CNT_W'(MAX_CUTS)) ? CUT_CNT_W'(MAX_CUTS)
                                                          : active_cuts_r;
  assign cut_idx = cut_r[CUT_IDX_W-1:0];
  assign zc      = ZW'(plane_z(cut_idx));
  assign in_range = (ZW'(pz_r) <= zc) && (zc <= ZW'(cz_r));
  assign scan_end = !have_prev_r || rejected_r || (cut_r >= n_cuts);
  assign emit_ok  = !out_valid_r || !out_stall;
  assign fail     = stat.done && (plane_keep_inside(cut_idx) != stat.in_radius);

  // Sequence the planes of one segment
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DONE;
        else if (in_range) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (stat.done) state_nxt = fail ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (!last_r || emit_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_cuts_r <= ACTIVE_CUTS_RST;
      have_prev_r   <= 1'b0;
      rejected_r    <= 1'b0;
      cut_r         <= '0;
      start_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;
      if (cfg_we) begin
        active_cuts_r <= cfg_wdata;
      end
      // load a result on the last point, drop it once taken
      if (state_r == S_DONE && last_r && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cut_r <= '0;
        end
        S_SCAN: begin
          if (!scan_end) begin
            if (in_range) start_r <= 1'b1;
            else cut_r <= cut_r + 1'b1;
          end
        end
        S_CALC: begin
          if (stat.done) begin
            if (fail) rejected_r <= 1'b1;
            else cut_r <= cut_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!last_r) begin
            have_prev_r <= 1'b1;
          end else if (emit_ok) begin
            have_prev_r <= 1'b0;
            rejected_r  <= 1'b0;
          end
        end
        default: begin
          cut_r <= '0;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r   <= in_pos_x;
      cy_r   <= in_pos_y;
      cz_r   <= in_pos_z;
      last_r <= in_last_point;
    end
    // load segment weights for the plane being started
    if (state_r == S_SCAN && !scan_end && in_range) begin
      r5_r <= plane_r5(cut_idx);
      if (pz_r == cz_r) begin
        wa_r <= '0;
        wb_r <= COORD_WIDTH'(1);
        dz_r <= COORD_WIDTH'(1);
      end else begin
        wa_r <= COORD_WIDTH'(ZW'(cz_r) - zc);
        wb_r <= COORD_WIDTH'(zc - ZW'(pz_r));
        dz_r <= cz_r - pz_r;
      end
    end
    // hold the point as the start of the next segment
    if (state_r == S_DONE) begin
      if (!last_r) begin
        px_r <= cx_r;
        py_r <= cy_r;
        pz_r <= cz_r;
      end else if (emit_ok) begin
        px_r       <= '0;
        py_r       <= '0;
        pz_r       <= '0;
        accepted_r <= !rejected_r;
      end
    end
  end

  tapc_plane_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_plane (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .px    (px_r),
    .py    (py_r),
    .cx    (cx_r),
    .cy    (cy_r),
    .wa    (wa_r),
    .wb    (wb_r),
    .dz    (dz_r),
    .r5    (r5_r),
    .stat  (stat)
  );

  assign out_valid    = out_valid_r;
  assign out_accepted = accepted_r;

  // A rejected track always has a previous point
  a_rej_prev: assert property (@(posedge clk) disable iff (!rst_n)
    rejected_r |-> have_prev_r)
    else $error("track rejected without a segment");

  // A plane check completes only for an active plane
  a_cut_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && stat.done) |-> (cut_r < n_cuts))
    else $error("plane check beyond the active cuts");

  // The last point loads a result and clears the track
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && last_r && emit_ok) |=>
      (out_valid_r && !have_prev_r && !rejected_r && state_r == S_IDLE))
    else $error("last point did not emit and clear");

  // An accepted beat starts the plane scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN && cut_r == '0))
    else $error("accepted beat did not start a scan");

endmodule
`default_nettype wire

### src/tapc_plane_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapc_plane_unit: radius test of one segment at one plane
// Runs a fixed 16-step program on a single shared multiplier. Builds the
// interpolation numerators Nx, Ny, then compares 25*(Nx^2 + Ny^2) against
// (5R*dz)^2, with every wide square split into two limbs.
// ----------------------------------------------------------------------------
module tapc_plane_unit
  import tapc_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [COORD_WIDTH-1:0] px,
  input  wire logic [COORD_WIDTH-1:0] py,
  input  wire logic [COORD_WIDTH-1:0] cx,
  input  wire logic [COORD_WIDTH-1:0] cy,
  input  wire logic [COORD_WIDTH-1:0] wa,
  input  wire logic [COORD_WIDTH-1:0] wb,
  input  wire logic [COORD_WIDTH-1:0] dz,
  input  wire logic [R5_W-1:0]        r5,
  output tapc_unit_stat_t             stat
);

  localparam int MW = COORD_WIDTH + 1;       // multiplier operand / limb width
  localparam int PW = 2 * MW;                // product width
  localparam int NW = 2 * COORD_WIDTH + 1;   // signed numerator width
  localparam int AW = 4 * COORD_WIDTH + 5;   // sum-of-squares width

  // Program steps
  localparam logic [3:0] ST_PXWA = 4'd0;
  localparam logic [3:0] ST_CXWB = 4'd1;
  localparam logic [3:0] ST_PYWA = 4'd2;
  localparam logic [3:0] ST_CYWB = 4'd3;
  localparam logic [3:0] ST_RDZ  = 4'd4;
  localparam logic [3:0] ST_XLL  = 4'd5;
  localparam logic [3:0] ST_XHH  = 4'd6;
  localparam logic [3:0] ST_XHL  = 4'd7;
  localparam logic [3:0] ST_YLL  = 4'd8;
  localparam logic [3:0] ST_YHH  = 4'd9;
  localparam logic [3:0] ST_YHL  = 4'd10;
  localparam logic [3:0] ST_RLL  = 4'd11;
  localparam logic [3:0] ST_RHH  = 4'd12;
  localparam logic [3:0] ST_RHL  = 4'd13;
  localparam logic [3:0] ST_LAST = 4'd15;

  logic             busy_r;
  logic [3:0]       step_r;
  logic             pbusy_r;
  logic [3:0]       pstep_r;
  logic             psign_r;
  logic [PW-1:0]    prod_r;
  logic [NW-1:0]    nx_r;
  logic [NW-1:0]    ny_r;
  logic [PW-1:0]    vx_r;
  logic [PW-1:0]    vy_r;
  logic [PW-1:0]    rd_r;
  logic [AW-1:0]    lhs_r;
  logic [AW-1:0]    rhs_r;

  logic [COORD_WIDTH-1:0] px_mag;
  logic [COORD_WIDTH-1:0] py_mag;
  logic [COORD_WIDTH-1:0] cx_mag;
  logic [COORD_WIDTH-1:0] cy_mag;
  logic [MW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic                   mul_sign;
  logic [NW-1:0]          term;
  logic [NW-1:0]          addend;
  logic [NW-1:0]          nx_mag;
  logic [NW-1:0]          ny_mag;
  logic [AW-1:0]          prod_ext;

  // Magnitudes of the point coordinates
  assign px_mag = px[COORD_WIDTH-1] ? (~px + 1'b1) : px;
  assign py_mag = py[COORD_WIDTH-1] ? (~py + 1'b1) : py;
  assign cx_mag = cx[COORD_WIDTH-1] ? (~cx + 1'b1) : cx;
  assign cy_mag = cy[COORD_WIDTH-1] ? (~cy + 1'b1) : cy;

  // Pick multiplier operands for the current step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sign = 1'b0;
    case (step_r)
      ST_PXWA: begin
        mul_a = MW'(px_mag); mul_b = MW'(wa); mul_sign = px[COORD_WIDTH-1];
      end
      ST_CXWB: begin
        mul_a = MW'(cx_mag); mul_b = MW'(wb); mul_sign = cx[COORD_WIDTH-1];
      end
      ST_PYWA: begin
        mul_a = MW'(py_mag); mul_b = MW'(wa); mul_sign = py[COORD_WIDTH-1];
      end
      ST_CYWB: begin
        mul_a = MW'(cy_mag); mul_b = MW'(wb); mul_sign = cy[COORD_WIDTH-1];
      end
      ST_RDZ: begin
        mul_a = MW'(r5); mul_b = MW'(dz);
      end
      ST_XLL: begin mul_a = vx_r[MW-1:0];  mul_b = vx_r[MW-1:0];  end
      ST_XHH: begin mul_a = vx_r[PW-1:MW]; mul_b = vx_r[PW-1:MW]; end
      ST_XHL: begin mul_a = vx_r[PW-1:MW]; mul_b = vx_r[MW-1:0];  end
      ST_YLL: begin mul_a = vy_r[MW-1:0];  mul_b = vy_r[MW-1:0];  end
      ST_YHH: begin mul_a = vy_r[PW-1:MW]; mul_b = vy_r[PW-1:MW]; end
      ST_YHL: begin mul_a = vy_r[PW-1:MW]; mul_b = vy_r[MW-1:0];  end
      ST_RLL: begin mul_a = rd_r[MW-1:0];  mul_b = rd_r[MW-1:0];  end
      ST_RHH: begin mul_a = rd_r[PW-1:MW]; mul_b = rd_r[PW-1:MW]; end
      ST_RHL: begin mul_a = rd_r[PW-1:MW]; mul_b = rd_r[MW-1:0];  end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Signed addend for the numerators, magnitudes for the squares
  assign term     = NW'(prod_r);
  assign addend   = psign_r ? (~term + 1'b1) : term;
  assign nx_mag   = nx_r[NW-1] ? (~nx_r + 1'b1) : nx_r;
  assign ny_mag   = ny_r[NW-1] ? (~ny_r + 1'b1) : ny_r;
  assign prod_ext = AW'(prod_r);

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= '0;
      pbusy_r <= 1'b0;
    end else begin
      pbusy_r <= busy_r;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == ST_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r  <= PW'(mul_a) * PW'(mul_b);
    psign_r <= mul_sign;
    pstep_r <= step_r;
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (pbusy_r) begin
      case (pstep_r)
        ST_PXWA: nx_r <= addend;
        ST_CXWB: nx_r <= nx_r + addend;
        ST_PYWA: begin
          ny_r <= addend;
          vx_r <= (PW'(nx_mag) << 2) + PW'(nx_mag);
        end
        ST_CYWB: ny_r <= ny_r + addend;
        ST_RDZ: begin
          rd_r <= prod_r;
          vy_r <= (PW'(ny_mag) << 2) + PW'(ny_mag);
        end
        ST_XLL:  lhs_r <= prod_ext;
        ST_XHH:  lhs_r <= lhs_r + (prod_ext << (2 * MW));
        ST_XHL:  lhs_r <= lhs_r + (prod_ext << (MW + 1));
        ST_YLL:  lhs_r <= lhs_r + prod_ext;
        ST_YHH:  lhs_r <= lhs_r + (prod_ext << (2 * MW));
        ST_YHL:  lhs_r <= lhs_r + (prod_ext << (MW + 1));
        ST_RLL:  rhs_r <= prod_ext;
        ST_RHH:  rhs_r <= rhs_r + (prod_ext << (2 * MW));
        ST_RHL:  rhs_r <= rhs_r + (prod_ext << (MW + 1));
        default: begin
          rhs_r <= rhs_r;
        end
      endcase
    end
  end

  // Report the compare on the final step
  assign stat.done      = busy_r && (step_r == ST_LAST);
  assign stat.in_radius = (lhs_r < rhs_r);

  // A new check never starts while one is running
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("plane unit started while busy");

  // The final step ends the run
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !busy_r)
    else $error("plane unit kept running after its final step");

  // Accumulate stage works on the step counter value of the previous cycle
  a_pipe_trail: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> pbusy_r && (pstep_r == $past(step_r)))
    else $error("multiply stage out of step with the counter");

endmodule
`default_nettype wire

### test/track_aperture_plane_cut_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_aperture_plane_cut_tb: self-checking bench for the plane cut
// Streams whole tracks into the block and predicts each track's verdict with
// an exact wide-integer model of the plane crossings. Every verdict beat is
// compared with the oldest prediction. The run covers boundary radii,
// zero-length and backward segments, single-point tracks, cut counts from
// zero to saturation, random stalls on both sides and a long output
// hold-off.
// ----------------------------------------------------------------------------
module track_aperture_plane_cut_tb
  import tapc_pkg::*;
();

  localparam int CW            = 20;
  localparam int Z_TOP         = 528000;
  localparam int PLANES        = 8;
  localparam int IDLE_PCT      = 11;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CW-1:0]        z;
    logic                 last;
  } point_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CUT_CNT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [CW-1:0]        in_pos_x;
  logic [CW-1:0]        in_pos_y;
  logic [CW-1:0]        in_pos_z;
  logic                 in_last_point;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_accepted;

  // Track predictor state
  logic [CUT_CNT_W-1:0] cut_count;
  longint               trk_x, trk_y, trk_z;
  bit                   trk_open, trk_failed;
  bit                   verdict_q[$];
  point_t               track_buf[$];

  // Traffic control and bookkeeping
  bit                   calm;
  bit                   hold_request;
  int unsigned          hold_left;
  int unsigned          cycle_count;
  int                   error_count;
  int                   items_sent, tracks_sent, settings_used;
  int                   verdicts_pass, verdicts_fail;

  track_aperture_plane_cut #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_last_point(in_last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_accepted (out_accepted)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Plane table: z in 1/16 mm, limit as 5*R in 1/16 mm, cut kind
  function automatic longint cut_plane_z(input int idx);
    case (idx)
      0, 1:    return 95600;
      2, 3:    return 451648;
      4:       return 204800;
      5:       return 284976;
      6:       return 312000;
      default: return 387200;
    endcase
  endfunction

  function automatic longint unsigned cut_limit5(input int idx);
    case (idx)
      0:       return 2824;
      1:       return 7840;
      2:       return 55200;
      3:       return 96000;
      4:       return 29984;
      5:       return 51240;
      6:       return 54400;
      default: return 84320;
    endcase
  endfunction

  function automatic bit cut_keeps_inside(input int idx);
    return (idx != 0) && (idx != 2);
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Strictly inside radius: 25*(Nx^2 + Ny^2) < (5R)^2 * dz^2
  function automatic bit within_radius(input longint unsigned nx, input longint unsigned ny,
                                       input longint unsigned span,
                                       input longint unsigned r5);
    logic [159:0] ax, ay, ad, ar, lhs, rhs;
    ax  = nx;
    ay  = ny;
    ad  = span;
    ar  = r5;
    lhs = (ax * ax + ay * ay) * 160'd25;
    rhs = ar * ar * ad * ad;
    return lhs < rhs;
  endfunction

  // Advance the track predictor by one accepted point
  function automatic void trace_point(input point_t p);
    longint            cx, cy, cz, zc, wa, wb;
    longint unsigned   nx, ny, span;
    int                n;
    bit                hit_in;
    cx = p.x;
    cy = p.y;
    cz = longint'({44'd0, p.z});
    n  = (cut_count > PLANES) ? PLANES : int'(cut_count);
    if (trk_open && !trk_failed) begin
      for (int j = 0; j < n && !trk_failed; j++) begin
        zc = cut_plane_z(j);
        if (trk_z <= zc && zc <= cz) begin
          if (cz == trk_z) begin
            // zero-length segment: test the point itself
            nx   = magnitude(cx);
            ny   = magnitude(cy);
            span = 1;
          end else begin
            wa   = cz - zc;
            wb   = zc - trk_z;
            nx   = magnitude(trk_x * wa + cx * wb);
            ny   = magnitude(trk_y * wa + cy * wb);
            span = cz - trk_z;
          end
          hit_in = within_radius(nx, ny, span, cut_limit5(j));
          if (cut_keeps_inside(j) != hit_in) trk_failed = 1'b1;
        end
      end
    end
    trk_x    = cx;
    trk_y    = cy;
    trk_z    = cz;
    trk_open = 1'b1;
    if (p.last) begin
      verdict_q.insert(verdict_q.size(), !trk_failed);
      trk_x      = 0;
      trk_y      = 0;
      trk_z      = 0;
      trk_open   = 1'b0;
      trk_failed = 1'b0;
    end
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  function automatic void add_point(input longint x, input longint y, input longint z);
    point_t p;
    p.x    = CW'(x);
    p.y    = CW'(y);
    p.z    = CW'(z);
    p.last = 1'b0;
    track_buf.insert(track_buf.size(), p);
  endfunction

  // Offer one point beat, with an occasional gap before it
  task automatic send_point(input point_t p);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pos_x      <= p.x;
    in_pos_y      <= p.y;
    in_pos_z      <= p.z;
    in_last_point <= p.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trace_point(p);
    items_sent++;
  endtask

  // Send the buffered track, marking its final point
  task automatic send_track();
    point_t p;
    for (int i = 0; i < track_buf.size(); i++) begin
      p      = track_buf[i];
      p.last = (i == track_buf.size() - 1);
      send_point(p);
    end
    track_buf.delete();
    tracks_sent++;
  endtask

  // Drop valid, drain all verdicts, then let the last non-final point finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Track that stays within every aperture, one straight radial direction
  task automatic build_clean_track();
    longint kz[8];
    int     kr[8];
    int     nk;
    real    ang, c, s, f, r, zz;
    ang   = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    c     = $cos(ang);
    s     = $sin(ang);
    kz[0] = $urandom_range(0, 90000);
    kr[0] = $urandom_range(600, 1500);
    kz[1] = 95600;
    kr[1] = $urandom_range(600, 1500);
    kz[2] = 204800;
    kr[2] = $urandom_range(600, 5900);
    kz[3] = 284976;
    kr[3] = $urandom_range(600, 10200);
    kz[4] = 312000;
    kr[4] = $urandom_range(600, 10800);
    kz[5] = 387200;
    kr[5] = $urandom_range(600, 16800);
    kz[6] = 451648;
    kr[6] = $urandom_range(11100, 19100);
    kz[7] = $urandom_range(452000, Z_TOP);
    kr[7] = $urandom_range(11100, 19100);
    // shift some knots off their plane so the plane falls mid-segment
    for (int i = 1; i < 7; i++)
      if ($urandom_range(0, 99) < 30) kz[i] += int'($urandom_range(0, 400)) - 200;
    nk = ($urandom_range(0, 1) == 1) ? 8 : 7;
    if ($urandom_range(0, 99) < 15) nk = $urandom_range(1, nk);
    for (int i = 0; i < nk; i++) begin
      add_point($rtoi(kr[i] * c), $rtoi(kr[i] * s), kz[i]);
      if ($urandom_range(0, 99) < 10) add_point($rtoi(kr[i] * c), $rtoi(kr[i] * s), kz[i]);
      if (i + 1 < nk && $urandom_range(0, 99) < 40) begin
        f  = $urandom_range(1, 99) / 100.0;
        r  = kr[i] + f * (kr[i+1] - kr[i]);
        zz = kz[i] + f * (kz[i+1] - kz[i]);
        add_point($rtoi(r * c), $rtoi(r * s), $rtoi(zz));
      end
    end
  endtask

  // Points anywhere in the field range, z in any order
  task automatic build_noise_track(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.x    = CW'($urandom());
      p.y    = CW'($urandom());
      p.z    = CW'($urandom_range(0, Z_TOP));
      p.last = 1'b0;
      track_buf.insert(track_buf.size(), p);
    end
  endtask

  // Mixed traffic: mostly clean tracks, some bent, noise and stacked on a plane
  task automatic run_tracks(input int budget);
    int     stop_count, kind, idx, zp, n;
    point_t p;
    stop_count = items_sent + budget;
    while (items_sent < stop_count) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        build_clean_track();
        if ($urandom_range(0, 99) < 25) begin
          // bend one point off the clean path
          idx = $urandom_range(0, track_buf.size() - 1);
          p   = track_buf[idx];
          p.x = CW'(int'($urandom_range(0, 40000)) - 20000);
          p.y = CW'(int'($urandom_range(0, 40000)) - 20000);
          track_buf[idx] = p;
        end
      end else if (kind < 85) begin
        build_noise_track($urandom_range(2, 6));
      end else if (kind < 93) begin
        build_noise_track(1);
      end else begin
        // all points on one plane: zero-length segments only
        zp = int'(cut_plane_z($urandom_range(0, PLANES - 1)));
        n  = $urandom_range(2, 4);
        for (int i = 0; i < n; i++)
          add_point(int'($urandom_range(0, 4000)) - 2000,
                    int'($urandom_range(0, 4000)) - 2000, zp);
      end
      send_track();
    end
  endtask

  // Change the cut count while idle, then run traffic
  task automatic run_phase(input logic [CUT_CNT_W-1:0] cuts, input int budget);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cuts;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cut_count  = cuts;
    settings_used++;
    run_tracks(budget);
  endtask

  task automatic test_directed();
    // single-point track at the field extremes
    add_point(524287, -524288, Z_TOP);
    send_track();
    // radius just outside and just inside the smallest keep-outside limit
    add_point(565, 0, 95600);
    add_point(565, 0, 95600);
    send_track();
    add_point(564, 0, 95600);
    add_point(564, 0, 95600);
    send_track();
    // radius exactly on a keep-inside limit, then one below
    add_point(0, 1568, 95600);
    add_point(0, 1568, 95600);
    send_track();
    add_point(0, -1567, 95600);
    add_point(0, -1567, 95600);
    send_track();
    // backward segment checks no plane
    add_point(0, 0, Z_TOP);
    add_point(0, 0, 0);
    send_track();
    // extreme coordinates across every plane
    add_point(-524288, 524287, 0);
    add_point(524287, -524288, Z_TOP);
    send_track();
    // segment ending right on a plane
    add_point(600, 0, 0);
    add_point(-800, 0, 95600);
    send_track();
  endtask

  task automatic test_cut_settings();
    run_phase(4'd0, 50);
    run_phase(4'd15, 50);
    run_phase(4'd1, 50);
    run_phase(4'd8, 50);
    run_phase(4'd3, 50);
    run_phase(4'd9, 50);
    run_phase(4'd5, 50);
  endtask

  // Hold the output long enough that a second verdict blocks the input
  task automatic test_backpressure();
    wait_idle();
    hold_request = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 1) build_noise_track(1);
      else build_noise_track(2);
      send_track();
    end
    wait_idle();
  endtask

  task automatic test_quiet();
    calm = 1'b1;
    run_tracks(150);
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_random();
    repeat (5) run_phase(CUT_CNT_W'($urandom_range(0, 15)), 160);
  endtask

  // Result receiver: random stalls, or a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare each verdict beat with the oldest prediction
  always @(posedge clk) begin : check_verdicts
    bit want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("verdict %0b with no track pending", out_accepted));
      end else begin
        want = verdict_q.pop_front();
        if (out_accepted !== want)
          flag_error($sformatf("accepted expected %0b, got %0b", want, out_accepted));
        if (want) verdicts_pass++;
        else verdicts_fail++;
      end
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d verdicts pending", cycle_count, verdict_q.size());
    $display("** track_aperture_plane_cut: FAILED **");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_pos_z      <= '0;
    in_last_point <= 1'b0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    cut_count     = 4'd8;
    trk_x         = 0;
    trk_y         = 0;
    trk_z         = 0;
    trk_open      = 1'b0;
    trk_failed    = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    tracks_sent   = 0;
    settings_used = 1;
    verdicts_pass = 0;
    verdicts_fail = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_cut_settings();
    test_backpressure();
    test_quiet();
    test_random();
    wait_idle();

    $display("Sent %0d points in %0d tracks under %0d cut-count settings, with stalls",
             items_sent, tracks_sent, settings_used);
    $display("and a %0d-cycle output hold-off; %0d accepted, %0d rejected, %0d mismatches.",
             HOLD_CYCLES, verdicts_pass, verdicts_fail, error_count);
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("** track_aperture_plane_cut: PASSED **");
    end else begin
      $display("** track_aperture_plane_cut: FAILED **");
    end
    $finish;
  end

endmodule
